### rtl/core/assert_macros.svh
// assertion macros for the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on the same clock edge
`define ASSERT_IMPL(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// implication checked a fixed number of edges later
`define ASSERT_DELAY(label, clk, rst, pre, n, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> ##n (post)) \
      else $error(msg);

`endif

### rtl/core/jdcal_pkg.sv
// constants, types and tables for the julian day to calendar date converter
package jdcal_pkg;

   localparam int JD_W      = 64;
   localparam int FRAC_BITS = 40;
   localparam int INT_W     = JD_W - FRAC_BITS;
   localparam int LO_W      = 20;
   localparam int HI_W      = FRAC_BITS - LO_W;
   localparam int US_W      = 37;
   localparam int USS_W     = US_W + 2;
   localparam int OFF_W     = 11;
   localparam int OFFUS_W   = 37;
   localparam int YEAR_W    = 17;

   localparam logic [US_W-1:0]         US_PER_DAY    = 37'd86400000000;
   localparam logic [US_W-1:0]         US_HALF_DAY   = 37'd43200000000;
   localparam logic signed [26:0]      US_PER_MINUTE = 27'sd60000000;

   // day count widths
   localparam int ZW   = INT_W + 1;
   localparam int ZS_W = INT_W + 2;
   localparam logic [ZW-1:0] GREG_START = ZW'(2299161);

   // gregorian century correction
   localparam int N1_W = ZW + 2;
   localparam logic [N1_W-1:0] N1_OFFSET = N1_W'(7468865);
   localparam int S1   = N1_W;
   localparam int M1_W = N1_W - 16;
   localparam longint unsigned M1_VAL = (64'd1 << S1) / 64'd146097;
   localparam logic [M1_W-1:0] M1 = M1_W'(M1_VAL);
   localparam int AW   = N1_W - 17;

   // year count
   localparam int BW   = ZW + 1;
   localparam int N2_W = BW + 5;
   localparam int CW   = N2_W - 12;
   localparam int S2   = N2_W;
   localparam int M2_W = N2_W - 12;
   localparam longint unsigned M2_VAL = (64'd1 << S2) / 64'd7305;
   localparam logic [M2_W-1:0] M2 = M2_W'(M2_VAL);
   localparam int DW   = CW + 11;
   localparam int YCW  = CW + 2;

   // month count
   localparam int BD_W = 9;
   localparam int E_W  = 4;
   localparam int S3   = 24;
   localparam int M3_W = 20;
   localparam longint unsigned M3_VAL = ((64'd1 << S3) * 64'd10000) / 64'd306001;
   localparam logic [M3_W-1:0] M3 = M3_W'(M3_VAL);
   localparam int R3_W = 23;

   // time of day
   localparam int T6_W  = US_W - 6;
   localparam int S4    = 31;
   localparam int M4_W  = 18;
   localparam logic [M4_W-1:0] M4 = M4_W'((64'd1 << S4) / 64'd15625);
   localparam int SE_W  = 18;
   localparam int SEC_W = 17;
   localparam int S5    = 24;
   localparam int M5_W  = 13;
   localparam logic [M5_W-1:0] M5 = M5_W'((64'd1 << S5) / 64'd3600);
   localparam int S6    = 24;
   localparam int M6_W  = 19;
   localparam logic [M6_W-1:0] M6 = M6_W'((64'd1 << S6) / 64'd60);

   typedef struct packed {
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic [19:0] microsecond;
   } tod_type;

   // floor(30.6001 * e)
   function automatic logic [BD_W-1:0] days_before(input logic [E_W-1:0] e);
      logic [BD_W-1:0] r;
      case (e)
         4'd0:  r = 9'd0;
         4'd1:  r = 9'd30;
         4'd2:  r = 9'd61;
         4'd3:  r = 9'd91;
         4'd4:  r = 9'd122;
         4'd5:  r = 9'd153;
         4'd6:  r = 9'd183;
         4'd7:  r = 9'd214;
         4'd8:  r = 9'd244;
         4'd9:  r = 9'd275;
         4'd10: r = 9'd306;
         4'd11: r = 9'd336;
         4'd12: r = 9'd367;
         4'd13: r = 9'd397;
         4'd14: r = 9'd428;
         4'd15: r = 9'd459;
         default: r = 9'd0;
      endcase
      return r;
   endfunction

endpackage

### rtl/core/julian_day_to_calendar_date.sv
// julian day to calendar date and time of day, twelve stage pipeline
// throughput: one item per cycle, busy stays low, results cannot be held off
// stage count is set by the chain of reciprocal divisions in the date split
// reset clears the stage valid bits and sets the utc offset to zero
`include "assert_macros.svh"

module julian_day_to_calendar_date (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [jdcal_pkg::JD_W-1:0]           req_jd_value,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [jdcal_pkg::OFF_W-1:0]          csr_wdata,
   output logic                                 rsp_strobe,
   output logic                                 rsp_status,
   output logic signed [jdcal_pkg::YEAR_W-1:0]  rsp_year,
   output logic [3:0]                           rsp_month,
   output logic [4:0]                           rsp_day,
   output logic [4:0]                           rsp_hour,
   output logic [5:0]                           rsp_minute,
   output logic [5:0]                           rsp_second,
   output logic [19:0]                          rsp_microsecond
);
   import jdcal_pkg::*;

   localparam logic signed [USS_W-1:0] DAY_S = {2'b00, US_PER_DAY};

   // control
   logic [12:1]              vld_ff, vld_in;
   logic signed [OFF_W-1:0]  off_ff;
   logic                     accept;

   // stage 1
   logic [HI_W+US_W-1:0]     s1_phi_ff, s1_phi_in;
   logic [LO_W+US_W-1:0]     s1_plo_ff, s1_plo_in;
   logic signed [OFFUS_W-1:0] s1_offus_ff, s1_offus_in;
   logic [INT_W-1:0]         s1_z0_ff;
   logic                     s1_zero_ff;

   // stage 2
   logic [HI_W+US_W:0]       s2_sum;
   logic [US_W-1:0]          s2_us;
   logic signed [USS_W-1:0]  s2_uss_ff, s2_uss_in;
   logic [INT_W-1:0]         s2_z0_ff;
   logic                     s2_zero_ff;

   // stage 3
   logic signed [2:0]        s3_q;
   logic signed [USS_W-1:0]  s3_todw;
   logic signed [ZS_W-1:0]   s3_z_ff, s3_z_in;
   logic [US_W-1:0]          s3_tod_ff, s3_tod_in;
   logic [11:3]              inv_ff;

   // stage 4
   logic [N1_W-1:0]          s4_n1_ff, s4_n1_in;
   logic [N1_W+M1_W-1:0]     s4_prod1;
   logic [AW-1:0]            s4_ae_ff, s4_ae_in;
   logic [ZW-1:0]            s4_zu_ff;
   logic                     s4_greg_ff;
   logic [T6_W+M4_W-1:0]     s4_prod4;
   logic [SE_W-1:0]          s4_se_ff, s4_se_in;
   logic [US_W-1:0]          s4_tod_ff;

   // stage 5
   logic [N1_W-1:0]          s5_r1;
   logic [AW-1:0]            s5_alpha_ff, s5_alpha_in;
   logic [ZW-1:0]            s5_zu_ff;
   logic                     s5_greg_ff;
   logic [T6_W-1:0]          s5_r4, s5_rf;
   logic [SEC_W-1:0]         s5_secs_ff, s5_secs_in;
   logic [19:0]              s5_usec_ff, s5_usec_in;

   // stage 6
   logic [BW-1:0]            s6_b_ff, s6_b_in;
   logic [SEC_W+M5_W-1:0]    s6_prod5;
   logic [4:0]               s6_he_ff, s6_he_in;
   logic [SEC_W-1:0]         s6_secs_ff;
   logic [19:0]              s6_usec_ff;

   // stage 7
   logic [N2_W-1:0]          s7_n2_ff, s7_n2_in;
   logic [N2_W+M2_W-1:0]     s7_prod2;
   logic [CW-1:0]            s7_ce_ff, s7_ce_in;
   logic [BW-1:0]            s7_b_ff;
   logic [SEC_W-1:0]         s7_r5;
   logic [4:0]               s7_hour_ff, s7_hour_in;
   logic [11:0]              s7_rem_ff, s7_rem_in;
   logic [19:0]              s7_usec_ff;

   // stage 8
   logic [N2_W-1:0]          s8_r2;
   logic [CW-1:0]            s8_c_ff, s8_c_in;
   logic [BW-1:0]            s8_b_ff;
   logic [12+M6_W-1:0]       s8_prod6;
   logic [6:0]               s8_me_ff, s8_me_in;
   logic [11:0]              s8_rem_ff;
   logic [4:0]               s8_hour_ff;
   logic [19:0]              s8_usec_ff;

   // stage 9
   logic [DW-1:0]            s9_d;
   logic [DW-1:0]            s9_diff;
   logic [BD_W-1:0]          s9_bd_ff, s9_bd_in;
   logic [CW-1:0]            s9_c_ff;
   logic [11:0]              s9_r6;
   tod_type                  s9_tod_ff, s9_tod_in;

   // stage 10
   logic [BD_W+M3_W-1:0]     s10_prod3;
   logic [E_W-1:0]           s10_ee_ff, s10_ee_in;
   logic [BD_W-1:0]          s10_bd_ff;
   logic [CW-1:0]            s10_c_ff;
   tod_type                  s10_tod_ff;

   // stage 11
   logic [R3_W-1:0]          s11_r3;
   logic [E_W-1:0]           s11_e_ff, s11_e_in;
   logic [BD_W-1:0]          s11_bd_ff;
   logic [CW-1:0]            s11_c_ff;
   tod_type                  s11_tod_ff;

   // stage 12, output registers
   logic [3:0]               s12_month;
   logic signed [YCW-1:0]    s12_yfull;
   logic                     st_ff, st_in;
   logic [YEAR_W-1:0]        year_ff, year_in;
   logic [3:0]               month_ff, month_in;
   logic [4:0]               day_ff, day_in;
   tod_type                  otod_ff, otod_in;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start & ~busy;

   always_comb begin
      vld_in = {vld_ff[11:1], accept};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         off_ff <= '0;
      end else begin
         vld_ff <= vld_in;
         if (csr_valid && csr_ready) begin
            off_ff <= csr_wdata;
         end
      end
   end

   // stage 1: fraction products and offset
   assign s1_phi_in   = (HI_W+US_W)'(req_jd_value[FRAC_BITS-1:LO_W])
                        * (HI_W+US_W)'(US_PER_DAY);
   assign s1_plo_in   = (LO_W+US_W)'(req_jd_value[LO_W-1:0]) * (LO_W+US_W)'(US_PER_DAY);
   assign s1_offus_in = OFFUS_W'(off_ff) * OFFUS_W'(US_PER_MINUTE);

   // stage 2: microseconds of day plus half day and offset
   assign s2_sum    = (HI_W+US_W+1)'(s1_phi_ff) + (HI_W+US_W+1)'(s1_plo_ff[LO_W+US_W-1:LO_W]);
   assign s2_us     = s2_sum[FRAC_BITS-20+US_W-1:FRAC_BITS-20];
   assign s2_uss_in = $signed({2'b00, s2_us}) + $signed({2'b00, US_HALF_DAY})
                      + USS_W'(s1_offus_ff);

   // stage 3: day carry
   always_comb begin
      if (s2_uss_ff < 0) begin
         s3_q    = -3'sd1;
         s3_todw = s2_uss_ff + DAY_S;
      end else if (s2_uss_ff < DAY_S) begin
         s3_q    = 3'sd0;
         s3_todw = s2_uss_ff;
      end else if (s2_uss_ff < (DAY_S <<< 1)) begin
         s3_q    = 3'sd1;
         s3_todw = s2_uss_ff - DAY_S;
      end else begin
         s3_q    = 3'sd2;
         s3_todw = s2_uss_ff - (DAY_S <<< 1);
      end
   end
   assign s3_tod_in = s3_todw[US_W-1:0];
   assign s3_z_in   = $signed({2'b00, s2_z0_ff}) + ZS_W'(s3_q);

   // stage 4: century estimate, seconds estimate
   assign s4_n1_in = {s3_z_ff[ZW-1:0], 2'b00} - N1_OFFSET;
   assign s4_prod1 = (N1_W+M1_W)'(s4_n1_in) * (N1_W+M1_W)'(M1);
   assign s4_ae_in = s4_prod1[S1+AW-1:S1];
   assign s4_prod4 = (T6_W+M4_W)'(s3_tod_ff[US_W-1:6]) * (T6_W+M4_W)'(M4);
   assign s4_se_in = s4_prod4[S4+SE_W-1:S4];

   // stage 5: corrections
   assign s5_r1       = s4_n1_ff - N1_W'(s4_ae_ff) * N1_W'(146097);
   assign s5_alpha_in = (s5_r1 >= N1_W'(146097)) ? s4_ae_ff + AW'(1) : s4_ae_ff;
   assign s5_r4       = s4_tod_ff[US_W-1:6] - T6_W'(s4_se_ff) * T6_W'(15625);
   always_comb begin
      if (s5_r4 >= T6_W'(15625)) begin
         s5_secs_in = SEC_W'(s4_se_ff + SE_W'(1));
         s5_rf      = s5_r4 - T6_W'(15625);
      end else begin
         s5_secs_in = SEC_W'(s4_se_ff);
         s5_rf      = s5_r4;
      end
   end
   assign s5_usec_in = {s5_rf[13:0], s4_tod_ff[5:0]};

   // stage 6: march-based day count, hour estimate
   assign s6_b_in  = (s5_greg_ff ? BW'(s5_zu_ff) + BW'(1) + BW'(s5_alpha_ff)
                                   - BW'(s5_alpha_ff >> 2)
                                 : BW'(s5_zu_ff)) + BW'(1524);
   assign s6_prod5 = (SEC_W+M5_W)'(s5_secs_ff) * (SEC_W+M5_W)'(M5);
   assign s6_he_in = s6_prod5[S5+4:S5];

   // stage 7: year estimate, hour correction
   assign s7_n2_in = N2_W'(s6_b_ff) * N2_W'(20) - N2_W'(2442);
   assign s7_prod2 = (N2_W+M2_W)'(s7_n2_in) * (N2_W+M2_W)'(M2);
   assign s7_ce_in = s7_prod2[S2+CW-1:S2];
   assign s7_r5    = s6_secs_ff - SEC_W'(s6_he_ff) * SEC_W'(3600);
   always_comb begin
      if (s7_r5 >= SEC_W'(3600)) begin
         s7_hour_in = s6_he_ff + 5'd1;
         s7_rem_in  = 12'(s7_r5 - SEC_W'(3600));
      end else begin
         s7_hour_in = s6_he_ff;
         s7_rem_in  = 12'(s7_r5);
      end
   end

   // stage 8: year correction, minute estimate
   assign s8_r2    = s7_n2_ff - N2_W'(s7_ce_ff) * N2_W'(7305);
   assign s8_c_in  = (s8_r2 >= N2_W'(7305)) ? s7_ce_ff + CW'(1) : s7_ce_ff;
   assign s8_prod6 = (12+M6_W)'(s7_rem_ff) * (12+M6_W)'(M6);
   assign s8_me_in = s8_prod6[S6+6:S6];

   // stage 9: day within year, minute correction
   assign s9_d     = (DW'(s8_c_ff) * DW'(1461)) >> 2;
   assign s9_diff  = DW'(s8_b_ff) - s9_d;
   assign s9_bd_in = s9_diff[BD_W-1:0];
   assign s9_r6    = s8_rem_ff - 12'(s8_me_ff) * 12'd60;
   always_comb begin
      s9_tod_in.hour        = s8_hour_ff;
      s9_tod_in.microsecond = s8_usec_ff;
      if (s9_r6 >= 12'd60) begin
         s9_tod_in.minute = 6'(s8_me_ff + 7'd1);
         s9_tod_in.second = 6'(s9_r6 - 12'd60);
      end else begin
         s9_tod_in.minute = 6'(s8_me_ff);
         s9_tod_in.second = 6'(s9_r6);
      end
   end

   // stage 10: month estimate
   assign s10_prod3 = (BD_W+M3_W)'(s9_bd_ff) * (BD_W+M3_W)'(M3);
   assign s10_ee_in = s10_prod3[S3+E_W-1:S3];

   // stage 11: month correction
   assign s11_r3   = R3_W'(s10_bd_ff) * R3_W'(10000) - R3_W'(s10_ee_ff) * R3_W'(306001);
   assign s11_e_in = (s11_r3 >= R3_W'(306001)) ? s10_ee_ff + E_W'(1) : s10_ee_ff;

   // stage 12: calendar fields
   assign s12_month = (s11_e_ff < E_W'(14)) ? s11_e_ff - 4'd1 : s11_e_ff - 4'd13;
   assign s12_yfull = $signed({2'b00, s11_c_ff})
                      - ((s12_month > 4'd2) ? YCW'(4716) : YCW'(4715));
   always_comb begin
      if (inv_ff[11]) begin
         st_in    = 1'b1;
         year_in  = '0;
         month_in = '0;
         day_in   = '0;
         otod_in  = '0;
      end else begin
         st_in    = 1'b0;
         year_in  = s12_yfull[YEAR_W-1:0];
         month_in = s12_month;
         day_in   = 5'(s11_bd_ff - days_before(s11_e_ff));
         otod_in  = s11_tod_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_phi_ff   <= s1_phi_in;
      s1_plo_ff   <= s1_plo_in;
      s1_offus_ff <= s1_offus_in;
      s1_z0_ff    <= req_jd_value[JD_W-1:FRAC_BITS];
      s1_zero_ff  <= (req_jd_value == '0);

      s2_uss_ff   <= s2_uss_in;
      s2_z0_ff    <= s1_z0_ff;
      s2_zero_ff  <= s1_zero_ff;

      s3_z_ff     <= s3_z_in;
      s3_tod_ff   <= s3_tod_in;
      inv_ff      <= {inv_ff[10:3], s2_zero_ff | s3_z_in[ZS_W-1]};

      s4_n1_ff    <= s4_n1_in;
      s4_ae_ff    <= s4_ae_in;
      s4_zu_ff    <= s3_z_ff[ZW-1:0];
      s4_greg_ff  <= (s3_z_ff[ZW-1:0] >= GREG_START);
      s4_se_ff    <= s4_se_in;
      s4_tod_ff   <= s3_tod_ff;

      s5_alpha_ff <= s5_alpha_in;
      s5_zu_ff    <= s4_zu_ff;
      s5_greg_ff  <= s4_greg_ff;
      s5_secs_ff  <= s5_secs_in;
      s5_usec_ff  <= s5_usec_in;

      s6_b_ff     <= s6_b_in;
      s6_he_ff    <= s6_he_in;
      s6_secs_ff  <= s5_secs_ff;
      s6_usec_ff  <= s5_usec_ff;

      s7_n2_ff    <= s7_n2_in;
      s7_ce_ff    <= s7_ce_in;
      s7_b_ff     <= s6_b_ff;
      s7_hour_ff  <= s7_hour_in;
      s7_rem_ff   <= s7_rem_in;
      s7_usec_ff  <= s6_usec_ff;

      s8_c_ff     <= s8_c_in;
      s8_b_ff     <= s7_b_ff;
      s8_me_ff    <= s8_me_in;
      s8_rem_ff   <= s7_rem_ff;
      s8_hour_ff  <= s7_hour_ff;
      s8_usec_ff  <= s7_usec_ff;

      s9_bd_ff    <= s9_bd_in;
      s9_c_ff     <= s8_c_ff;
      s9_tod_ff   <= s9_tod_in;

      s10_ee_ff   <= s10_ee_in;
      s10_bd_ff   <= s9_bd_ff;
      s10_c_ff    <= s9_c_ff;
      s10_tod_ff  <= s9_tod_ff;

      s11_e_ff    <= s11_e_in;
      s11_bd_ff   <= s10_bd_ff;
      s11_c_ff    <= s10_c_ff;
      s11_tod_ff  <= s10_tod_ff;

      st_ff       <= st_in;
      year_ff     <= year_in;
      month_ff    <= month_in;
      day_ff      <= day_in;
      otod_ff     <= otod_in;
   end

   assign rsp_strobe      = vld_ff[12];
   assign rsp_status      = st_ff;
   assign rsp_year        = $signed(year_ff);
   assign rsp_month       = month_ff;
   assign rsp_day         = day_ff;
   assign rsp_hour        = otod_ff.hour;
   assign rsp_minute      = otod_ff.minute;
   assign rsp_second      = otod_ff.second;
   assign rsp_microsecond = otod_ff.microsecond;

   `ASSERT_DELAY(a_latency, clock, reset, start && !busy, 12, rsp_strobe,
      "item lost in pipeline")
   `ASSERT_IMPL(a_invalid_zero, clock, reset, rsp_strobe && rsp_status,
      rsp_year == '0 && rsp_month == '0 && rsp_day == '0 && rsp_hour == '0
      && rsp_minute == '0 && rsp_second == '0 && rsp_microsecond == '0,
      "invalid item not cleared")
   `ASSERT_IMPL(a_field_range, clock, reset, rsp_strobe && !rsp_status,
      rsp_month >= 4'd1 && rsp_month <= 4'd12 && rsp_day >= 5'd1 && rsp_hour <= 5'd23
      && rsp_minute <= 6'd59 && rsp_second <= 6'd59 && rsp_microsecond <= 20'd999999,
      "result field out of range")

endmodule

### bench/tb_top.sv
// self-checking bench for the julian day to calendar date converter
module tb_top;
   import jdcal_pkg::*;

   typedef struct packed {
      logic        status;
      logic [16:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic [19:0] microsecond;
   } date_type;

   localparam longint DAY_US  = 64'sd86400000000;
   localparam longint HALF_US = 64'sd43200000000;
   localparam longint MIN_US  = 64'sd60000000;
   localparam longint GREG    = 64'sd2299161;
   localparam int     LATENCY = 12;
   localparam int     LIMIT   = 200000;

   class date_scoreboard;
      date_type dates_due[$];
      longint   offset_min;
      int       mismatches;

      function longint fdiv(longint n, longint d);
         longint q;
         q = n / d;
         if ((n % d) != 0 && n < 0) q--;
         return q;
      endfunction

      function date_type convert(logic [63:0] jd);
         date_type r;
         longint z, us, t, a, b, c, d, e, al, mo, yr;
         r = '0;
         if (jd == 0) begin
            r.status = 1'b1;
            return r;
         end
         us = longint'(((jd[39:20] * 64'd86400000000)
                        + ((jd[19:0] * 64'd86400000000) >> 20)) >> 20);
         us = us + HALF_US + offset_min * MIN_US;
         z  = longint'(jd[63:40]) + fdiv(us, DAY_US);
         t  = us - fdiv(us, DAY_US) * DAY_US;
         if (z < 0) begin
            r.status = 1'b1;
            return r;
         end
         if (z < GREG) begin
            a = z;
         end else begin
            al = (4 * z - 7468865) / 146097;
            a  = z + 1 + al - al / 4;
         end
         b  = a + 1524;
         c  = (20 * b - 2442) / 7305;
         d  = (1461 * c) / 4;
         e  = (10000 * (b - d)) / 306001;
         mo = (e < 14) ? e - 1 : e - 13;
         yr = (mo > 2) ? c - 4716 : c - 4715;
         r.year        = yr[16:0];
         r.month       = mo[3:0];
         r.day         = 5'(b - d - (306001 * e) / 10000);
         r.hour        = 5'(t / 64'sd3600000000);
         r.minute      = 6'((t / MIN_US) % 60);
         r.second      = 6'((t / 1000000) % 60);
         r.microsecond = 20'(t % 1000000);
         return r;
      endfunction

      function void note_item(logic [63:0] jd);
         dates_due.push_back(convert(jd));
      endfunction

      function void check_date(date_type got);
         date_type want;
         if (dates_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %p", got);
            return;
         end
         want = dates_due.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p, actual %p", want, got);
         end
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic [JD_W-1:0]      req_jd_value = '0;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [OFF_W-1:0]     csr_wdata = '0;
   logic                 rsp_strobe, rsp_status;
   logic signed [YEAR_W-1:0] rsp_year;
   logic [3:0]           rsp_month;
   logic [4:0]           rsp_day, rsp_hour;
   logic [5:0]           rsp_minute, rsp_second;
   logic [19:0]          rsp_microsecond;

   date_scoreboard sb = new();
   int             cycles = 0;

   julian_day_to_calendar_date i_dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("FAIL");
         $finish;
      end
      if (!reset && start && !busy) sb.note_item(req_jd_value);
      if (!reset && rsp_strobe)
         sb.check_date({rsp_status, rsp_year, rsp_month, rsp_day, rsp_hour,
                        rsp_minute, rsp_second, rsp_microsecond});
   end

   task automatic send_item(logic [63:0] jd);
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
      start        = 1'b1;
      req_jd_value = jd;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain();
      start = 1'b0;
      while (sb.dates_due.size() != 0) @(negedge clock);
      repeat (LATENCY + 4) @(negedge clock);
   endtask

   task automatic write_offset(logic [OFF_W-1:0] v);
      csr_valid = 1'b1;
      csr_wdata = v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.offset_min = longint'($signed(v));
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic logic [63:0] random_jd();
      logic [63:0] jd;
      jd = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: jd[63:40] = 24'($urandom_range(0, 5500000));
         5: jd[63:40] = 24'($urandom_range(2299158, 2299163));
         6: jd[63:40] = 24'($urandom_range(0, 2));
         7: jd[63:40] = 24'hFFFFFF - 24'($urandom_range(0, 3));
         default: ;
      endcase
      return jd;
   endfunction

   logic [OFF_W-1:0] offsets[6];

   initial begin
      // most negative offset is the bare sign bit
      offsets = '{11'sd840, -11'sd840, 11'sd1023, 11'h400, 11'sd0, 11'sd0};
      offsets[5] = OFF_W'($urandom_range(0, 2047));
      repeat (11) @(negedge clock);
      reset = 1'b0;
      // directed items with the reset offset
      send_item(64'd0);
      send_item(64'd1);
      send_item('1);
      send_item({24'd0, 40'hFF_FFFF_FFFF});
      send_item({24'd1, 40'd0});
      send_item({24'd0, 40'h80_0000_0000});
      send_item({24'd2299160, 40'h7F_FFFF_FFFF});
      send_item({24'd2299160, 40'h80_0000_0000});
      send_item({24'd2299161, 40'd0});
      send_item({24'd2451544, 40'h80_0000_0000});
      send_item({24'hFFFFFF, 40'd0});
      send_item({24'd2460000, 40'h55_5555_5555});
      send_item({24'd1721423, 40'hAA_AAAA_AAAA});
      for (int i = 0; i < 60; i++) begin
         send_item(random_jd());
         if (i == 30) drain();
      end
      drain();
      foreach (offsets[p]) begin
         write_offset(offsets[p]);
         send_item(64'd1);
         send_item({24'd0, 40'h7F_FFFF_FFFF});
         send_item('1);
         for (int i = 0; i < 55; i++) send_item(random_jd());
         drain();
      end
      if (sb.mismatches == 0 && sb.dates_due.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule
